### sv/fsfd_pkg.sv
// ----------------------------------------------------------------------------
// fsfd_pkg
// Shared constants and types for the Fortran source form detector.
// ----------------------------------------------------------------------------
package fsfd_pkg;

   localparam int ByteWidth = 8;
   localparam int ColWidth  = 7;
   localparam int ModeWidth = 3;

   // scan mode codes
   localparam logic [ModeWidth-1:0] MODE_LINE_START = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_STATEMENT  = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_DQUOTE     = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_SQUOTE     = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_SKIP_LINE  = 3'd4;

   localparam logic [ColWidth-1:0] LABEL_LAST_COL = 7'd5;
   localparam logic [ColWidth-1:0] CONT_COL       = 7'd6;
   localparam logic [ColWidth-1:0] LAST_CHECK_COL = 7'd72;
   localparam logic [ColWidth-1:0] COL_MAX        = 7'd127;

   localparam logic [ByteWidth-1:0] CHR_LF     = 8'd10;
   localparam logic [ByteWidth-1:0] CHR_CR     = 8'd13;
   localparam logic [ByteWidth-1:0] CHR_TAB    = 8'd9;
   localparam logic [ByteWidth-1:0] CHR_SPACE  = 8'h20;
   localparam logic [ByteWidth-1:0] CHR_BANG   = 8'h21;
   localparam logic [ByteWidth-1:0] CHR_DQUOTE = 8'h22;
   localparam logic [ByteWidth-1:0] CHR_AMP    = 8'h26;
   localparam logic [ByteWidth-1:0] CHR_SQUOTE = 8'h27;
   localparam logic [ByteWidth-1:0] CHR_STAR   = 8'h2A;
   localparam logic [ByteWidth-1:0] CHR_ZERO   = 8'h30;
   localparam logic [ByteWidth-1:0] CHR_NINE   = 8'h39;
   localparam logic [ByteWidth-1:0] CHR_UPPER_C = 8'h43;
   localparam logic [ByteWidth-1:0] CHR_LOWER_C = 8'h63;

   typedef struct packed {
      logic [ModeWidth-1:0] mode;
      logic [ColWidth-1:0]  col;
      logic                 label_blank;
      logic                 free_seen;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      mode:        MODE_LINE_START,
      col:         '0,
      label_blank: 1'b0,
      free_seen:   1'b0
   };

endpackage

### sv/fsfd_scan.sv
// ----------------------------------------------------------------------------
// fsfd_scan
// Next-state logic of the line scanner for one source byte.
// ----------------------------------------------------------------------------
module fsfd_scan (
   input  fsfd_pkg::scan_state_type cur_state,
   input  logic [7:0]               byte_value,
   output fsfd_pkg::scan_state_type nxt_state
);
   import fsfd_pkg::*;

   logic                is_digit;
   logic                is_space;
   logic [ColWidth-1:0] col_inc;

   assign is_digit = (byte_value >= CHR_ZERO) && (byte_value <= CHR_NINE);
   assign is_space = (byte_value == CHR_SPACE);
   assign col_inc  = (cur_state.col < COL_MAX) ? cur_state.col + 7'd1 : cur_state.col;

   always_comb begin
      nxt_state = cur_state;
      priority if (cur_state.free_seen) begin
         nxt_state = cur_state;
      end else if (byte_value == CHR_CR || byte_value == CHR_LF) begin
         nxt_state.mode = MODE_LINE_START;
      end else if (cur_state.mode == MODE_LINE_START) begin
         priority if (is_space || byte_value == CHR_TAB || is_digit) begin
            nxt_state.mode        = MODE_STATEMENT;
            // leading tab stands for the whole label field
            nxt_state.col         = (byte_value == CHR_TAB) ? LABEL_LAST_COL : 7'd1;
            nxt_state.label_blank = is_space || (byte_value == CHR_TAB);
         end else if (byte_value == CHR_UPPER_C || byte_value == CHR_LOWER_C ||
                      byte_value == CHR_STAR || byte_value == CHR_BANG) begin
            nxt_state.mode = MODE_SKIP_LINE;
         end else begin
            nxt_state.free_seen = 1'b1;
         end
      end else if (cur_state.mode == MODE_SKIP_LINE) begin
         nxt_state = cur_state;
      end else begin
         nxt_state.col = col_inc;
         priority if (cur_state.mode == MODE_DQUOTE) begin
            if (byte_value == CHR_DQUOTE) begin
               nxt_state.mode = MODE_STATEMENT;
            end
         end else if (cur_state.mode == MODE_SQUOTE) begin
            if (byte_value == CHR_SQUOTE) begin
               nxt_state.mode = MODE_STATEMENT;
            end
         end else if (cur_state.mode != MODE_STATEMENT) begin
            nxt_state.mode = MODE_SKIP_LINE;
         end else begin
            if (col_inc <= LABEL_LAST_COL && !is_space) begin
               nxt_state.label_blank = 1'b0;
            end
            priority if (col_inc <= LABEL_LAST_COL && !is_digit && !is_space &&
                         byte_value != CHR_BANG) begin
               nxt_state.free_seen = 1'b1;
            end else if (col_inc == CONT_COL && !cur_state.label_blank &&
                         !is_space && byte_value != CHR_ZERO) begin
               nxt_state.free_seen = 1'b1;
            end else if (byte_value == CHR_BANG && col_inc != CONT_COL) begin
               nxt_state.mode = MODE_SKIP_LINE;
            end else if (byte_value == CHR_DQUOTE) begin
               nxt_state.mode = MODE_DQUOTE;
            end else if (byte_value == CHR_SQUOTE) begin
               nxt_state.mode = MODE_SQUOTE;
            end else if (col_inc > CONT_COL && col_inc <= LAST_CHECK_COL &&
                         byte_value == CHR_AMP) begin
               nxt_state.free_seen = 1'b1;
            end else begin
               nxt_state.mode = MODE_STATEMENT;
            end
         end
      end
   end

endmodule

### sv/fortran_source_form_detector.sv
// ----------------------------------------------------------------------------
// fortran_source_form_detector
// Classifies a byte stream as fixed-form (0) or free-form (1) Fortran.
// ----------------------------------------------------------------------------
//  channel  | dir | ports                     | contents
//  req_     | in  | tvalid tready tdata tlast | one file byte, tlast on final byte
//  rsp_     | out | tvalid tready tdata        | verdict, one word per file
//
//  unless stalled, one byte per cycle: byte register, scan logic, verdict register
//  scan state is updated as the registered byte moves through the scan logic
//  reset clears the scan state and both valid flags, synchronous, active high
//  a held verdict only stalls the stream when a further final byte is waiting
// ----------------------------------------------------------------------------
module fortran_source_form_detector (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] free_form, [7:1] zero
);
   import fsfd_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   scan_state_type state_ff, state_in;
   scan_state_type scan_nxt;
   logic           out_valid_ff, out_valid_in;
   logic           out_free_ff;
   logic           advance;
   logic           accept;

   fsfd_scan u_scan (
      .cur_state  (state_ff),
      .byte_value (in_byte_ff),
      .nxt_state  (scan_nxt)
   );

   // a final byte needs room in the verdict register
   assign advance = in_valid_ff &&
                    !(in_last_ff && out_valid_ff && !rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept = req_tvalid && req_tready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && !rsp_tready);

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = in_last_ff ? SCAN_RESET : scan_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= SCAN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_free_ff <= scan_nxt.free_seen;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_free_ff};

endmodule

### tb/tb_fortran_source_form_detector.sv
// ----------------------------------------------------------------------------
// tb_fortran_source_form_detector
// Self-checking bench for the Fortran source form detector. Byte streams of
// short generated source files, mostly well-formed fixed-form lines with
// random content plus corner files and noise, are fed through the request
// stream. A local scan model predicts the form verdict for each file, and
// every verdict word is compared in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fortran_source_form_detector;

   import fsfd_pkg::*;

   localparam int RX_HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int TAIL_CYCLES    = 16;

   // -------------------------------------------------------------------------
   // verdict scoreboard with its own copy of the scan state
   // -------------------------------------------------------------------------
   class form_scoreboard;
      logic [ModeWidth-1:0] mode;
      logic [ColWidth-1:0]  col;
      logic                 label_blank;
      logic                 free_seen;
      bit                   verdict_q[$];
      int                   errors;
      int                   byte_count;
      int                   file_count;
      int                   fixed_count;
      int                   free_count;

      function new();
         clear_scan();
      endfunction

      function void clear_scan();
         mode        = MODE_LINE_START;
         col         = '0;
         label_blank = 1'b0;
         free_seen   = 1'b0;
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= CHR_ZERO && b <= CHR_NINE;
      endfunction

      function void scan_byte(logic [7:0] b);
         if (free_seen) return;
         if (b == CHR_CR || b == CHR_LF) begin
            mode = MODE_LINE_START;
            return;
         end
         if (mode == MODE_LINE_START) begin
            if (b == CHR_SPACE || b == CHR_TAB || is_digit(b)) begin
               mode        = MODE_STATEMENT;
               // a leading tab stands for the whole label field
               col         = (b == CHR_TAB) ? LABEL_LAST_COL : 7'd1;
               label_blank = (b == CHR_SPACE || b == CHR_TAB);
            end else if (b == CHR_UPPER_C || b == CHR_LOWER_C ||
                         b == CHR_STAR || b == CHR_BANG) begin
               mode = MODE_SKIP_LINE;
            end else begin
               free_seen = 1'b1;
            end
            return;
         end
         if (mode == MODE_SKIP_LINE) return;
         if (col < COL_MAX) col = col + 7'd1;
         if (mode == MODE_DQUOTE) begin
            if (b == CHR_DQUOTE) mode = MODE_STATEMENT;
            return;
         end
         if (mode == MODE_SQUOTE) begin
            if (b == CHR_SQUOTE) mode = MODE_STATEMENT;
            return;
         end
         if (mode != MODE_STATEMENT) begin
            mode = MODE_SKIP_LINE;
            return;
         end
         if (col <= LABEL_LAST_COL) begin
            if (b != CHR_SPACE) label_blank = 1'b0;
            if (!is_digit(b) && b != CHR_SPACE && b != CHR_BANG) begin
               free_seen = 1'b1;
               return;
            end
         end
         if (col == CONT_COL && !label_blank && b != CHR_SPACE && b != CHR_ZERO) begin
            free_seen = 1'b1;
            return;
         end
         if (b == CHR_BANG && col != CONT_COL) begin
            mode = MODE_SKIP_LINE;
         end else if (b == CHR_DQUOTE) begin
            mode = MODE_DQUOTE;
         end else if (b == CHR_SQUOTE) begin
            mode = MODE_SQUOTE;
         end else if (col > CONT_COL && col <= LAST_CHECK_COL && b == CHR_AMP) begin
            free_seen = 1'b1;
         end
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         byte_count++;
         scan_byte(b);
         if (last) begin
            verdict_q.push_back(free_seen);
            if (free_seen) free_count++;
            else fixed_count++;
            file_count++;
            clear_scan();
         end
      endfunction

      function void check_verdict(logic [7:0] word);
         bit expected;
         if (verdict_q.size() == 0) begin
            $error("free_form: expected none, actual %0d", word[0]);
            errors++;
            return;
         end
         expected = verdict_q.pop_front();
         if (word[0] !== expected) begin
            $error("free_form: expected %0d, actual %0d", expected, word[0]);
            errors++;
         end
         if (word[7:1] !== 7'd0) begin
            $error("tdata pad: expected 0, actual %0h", word[7:1]);
            errors++;
         end
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block
   // -------------------------------------------------------------------------
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;   // [7:0] byte_value
   logic       req_tlast  = 1'b0;   // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] free_form, [7:1] zero

   form_scoreboard sb;
   logic [7:0]     file_bytes[$];
   bit             steady      = 1'b0;
   int             rx_hold_req = 0;
   int             rx_hold_seen = 0;
   int             rx_hold_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   fortran_source_form_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (rx_hold_seen != rx_hold_req) begin
         rx_hold_seen = rx_hold_req;
         rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 31);
      end
   end

   // monitor both streams; result side first so a word never meets its own byte
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (rsp_tvalid && rsp_tready) sb.check_verdict(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
      end
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // byte generators
   // -------------------------------------------------------------------------
   function automatic logic [7:0] pick_digit();
      return 8'($urandom_range(CHR_ZERO, CHR_NINE));
   endfunction

   function automatic logic [7:0] pick_label_byte();
      int r;
      r = $urandom_range(99);
      if (r < 60) return CHR_SPACE;
      if (r < 95) return pick_digit();
      if (r < 97) return CHR_BANG;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_text_byte(input bit clean);
      int r;
      r = $urandom_range(99);
      if (r < 50) return 8'($urandom_range(8'h41, 8'h5A));
      if (r < 62) return CHR_SPACE;
      if (r < 68) return CHR_DQUOTE;
      if (r < 74) return CHR_SQUOTE;
      if (r < 77) return CHR_BANG;
      if (r < 80) return CHR_TAB;
      if (r < 82 && !clean) return CHR_AMP;
      if (r < 92) return pick_digit();
      return 8'($urandom_range(255));
   endfunction

   function automatic void add_line_end();
      int r;
      r = $urandom_range(99);
      if (r < 50) begin
         file_bytes.push_back(CHR_LF);
      end else if (r < 80) begin
         file_bytes.push_back(CHR_CR);
         file_bytes.push_back(CHR_LF);
      end else if (r < 90) begin
         file_bytes.push_back(CHR_CR);
      end else begin
         file_bytes.push_back(CHR_LF);
         file_bytes.push_back(CHR_LF);
      end
   endfunction

   function automatic void add_statement_line(input bit clean);
      int         r;
      int         stop_col;
      int         body_len;
      bit         blank_label;
      logic [7:0] b;
      r = $urandom_range(99);
      blank_label = 1'b1;
      if (r < 5) begin
         // '&' at the first checked column, or at or just past the last one
         case ($urandom_range(2))
            0: stop_col = 7;
            1: stop_col = 72;
            default: stop_col = 73;
         endcase
         file_bytes.push_back(CHR_TAB);
         repeat (stop_col - 6) file_bytes.push_back(CHR_SPACE);
         file_bytes.push_back(CHR_AMP);
         return;
      end
      if (r < 30) begin
         file_bytes.push_back(CHR_TAB);
      end else begin
         b = $urandom_range(1) ? CHR_SPACE : pick_digit();
         if (b != CHR_SPACE) blank_label = 1'b0;
         file_bytes.push_back(b);
         for (int c = 2; c <= 5; c++) begin
            b = pick_label_byte();
            if (b != CHR_SPACE) blank_label = 1'b0;
            file_bytes.push_back(b);
         end
      end
      // continuation column
      r = $urandom_range(99);
      if (blank_label) begin
         if (r < 10) b = CHR_AMP;
         else if (r < 20) b = CHR_BANG;
         else b = pick_text_byte(clean);
      end else if (r < 10) begin
         b = pick_text_byte(clean);
      end else begin
         b = (r < 55) ? CHR_SPACE : CHR_ZERO;
      end
      file_bytes.push_back(b);
      r = $urandom_range(99);
      if (r < 85) body_len = $urandom_range(25);
      else if (r < 95) body_len = $urandom_range(40, 80);
      else body_len = $urandom_range(120, 140);
      repeat (body_len) file_bytes.push_back(pick_text_byte(clean));
   endfunction

   function automatic void add_comment_line();
      case ($urandom_range(3))
         0: file_bytes.push_back(CHR_UPPER_C);
         1: file_bytes.push_back(CHR_LOWER_C);
         2: file_bytes.push_back(CHR_STAR);
         default: file_bytes.push_back(CHR_BANG);
      endcase
      repeat ($urandom_range(30)) file_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void queue_text(input string s);
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
   endfunction

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   task automatic offer_byte(input logic [7:0] b, input logic last);
      while (!steady && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(255));
         req_tlast  <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         offer_byte(file_bytes[i], i == file_bytes.size() - 1);
      file_bytes.delete();
   endtask

   task automatic send_random_file();
      int n_lines;
      int r;
      bit clean;
      clean   = $urandom_range(1);
      n_lines = $urandom_range(1, 4);
      if ($urandom_range(9) == 0) add_line_end();
      for (int i = 0; i < n_lines; i++) begin
         r = $urandom_range(99);
         if (r < 70) begin
            add_statement_line(clean);
         end else if (r < 95) begin
            add_comment_line();
         end else begin
            file_bytes.push_back(8'($urandom_range(255)));
            repeat ($urandom_range(8)) file_bytes.push_back(pick_text_byte(clean));
         end
         if (i < n_lines - 1 || $urandom_range(1)) add_line_end();
      end
      send_file();
   endtask

   task automatic wait_for_verdicts(input int max_cycles);
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (sb.pending() != 0 && waited < max_cycles);
   endtask

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner files: extreme bytes, comment start, leading line ends,
      // tab label with continuation and '&', '!' in label, tab in label,
      // '&' inside both kinds of string
      file_bytes.push_back(8'h00);
      send_file();
      file_bytes.push_back(8'hFF);
      send_file();
      queue_text("c");
      send_file();
      file_bytes.push_back(CHR_LF);
      file_bytes.push_back(CHR_CR);
      file_bytes.push_back(CHR_STAR);
      send_file();
      queue_text("\t&&");
      send_file();
      queue_text("1!&");
      send_file();
      queue_text("9\t");
      send_file();
      queue_text("\t\"&");
      send_file();
      queue_text("\t'&");
      send_file();

      while (sb.byte_count < 300 || sb.file_count < 25) send_random_file();

      // long receiver hold-off while single-byte files keep coming
      rx_hold_req++;
      repeat (16) begin
         file_bytes.push_back(8'($urandom_range(255)));
         send_file();
      end
      wait_for_verdicts(DRAIN_LIMIT);

      steady = 1'b1;
      repeat (10) send_random_file();
      steady = 1'b0;

      while (sb.byte_count < 720 || sb.file_count < 70) send_random_file();

      wait_for_verdicts(DRAIN_LIMIT);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("free_form: %0d verdicts still expected at the end", sb.pending());
         sb.errors++;
      end
      $display("run covered %0d files in %0d bytes: %0d fixed-form, %0d free-form",
               sb.file_count, sb.byte_count, sb.fixed_count, sb.free_count);
      $display("with random stalls, a long output hold-off and a stall-free stretch");
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
sv/fsfd_pkg.sv
sv/fsfd_scan.sv
sv/fortran_source_form_detector.sv
tb/tb_fortran_source_form_detector.sv
